// ===== rtl/t4rgba_pkg.sv =====
// Shared types, constants and color expansion table for the tiled 4bpp to RGBA converter.
package t4rgba_pkg;

    localparam int DEF_MAX_WIDTH_TILES  = 32;
    localparam int DEF_MAX_HEIGHT_TILES = 32;

    localparam int PAL_DEPTH    = 256;
    localparam int PAL_AW       = 8;
    localparam int COLOR_W      = 15;
    localparam int CHAN_W       = 5;
    localparam int NIBBLE_W     = 4;
    localparam int BANK_W       = 4;
    localparam int WIDTH_REG_W  = 6;
    localparam int CFG_DATA_W   = 6;
    localparam int PIX_IDX_W    = 16;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 80;

    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [0:0] {
        OP_PAL_WRITE = 1'b0,
        OP_PIXEL     = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        REG_WIDTH_TILES  = 1'b0,
        REG_PALETTE_BANK = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    // floor(c * 255 / 31)
    localparam logic [7:0] EXPAND_LUT [0:31] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

endpackage

// ===== rtl/tiled_4bpp_to_rgba_converter_core.sv =====
// Top level: config registers, input unpacking, two pixel lanes and the merging output stage.
//
// Takes one word per cycle unless the output stalls, and returns one word per pixel byte,
// two RGBA8 pixels plus the raster index of the even one; palette writes return nothing.
// Pixels pass the palette lookup register in each lane, then the output register where the
// lanes and the index merge. Each lane holds its own copy of the 256-entry palette, so
// both nibbles of a byte are looked up in the same cycle. The palette has no reset; entries
// must be written before use. Write the config registers only while the block is idle.
module tiled_4bpp_to_rgba_converter_core
    import t4rgba_pkg::*;
#(
    parameter int MAX_WIDTH_TILES  = DEF_MAX_WIDTH_TILES,
    parameter int MAX_HEIGHT_TILES = DEF_MAX_HEIGHT_TILES
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // palette_index[7:0], palette_color[22:8], source_byte[30:23], zero[31]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic                  s_tuser,
    input  logic                  s_tlast,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_index[15:0], red/green/blue/alpha_even[47:16], red/green/blue/alpha_odd[79:48]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    logic [WIDTH_REG_W-1:0] width_tiles_reg;
    logic [BANK_W-1:0]      palette_bank_reg;

    logic [PAL_AW-1:0]   in_pal_index;
    logic [COLOR_W-1:0]  in_pal_color;
    logic [7:0]          in_source_byte;

    logic                 word_accept;
    logic                 pixel_accept;
    logic                 pal_we;
    logic [PIX_IDX_W-1:0] pixel_index;

    logic                 s1_valid_reg, s1_valid_next;
    logic [PIX_IDX_W-1:0] s1_index_reg;
    logic                 s1_last_reg;
    rgba_t                even_pixel;
    rgba_t                odd_pixel;

    logic                 load_out;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    assign in_pal_index   = s_tdata[7:0];
    assign in_pal_color   = s_tdata[22:8];
    assign in_source_byte = s_tdata[30:23];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_tiles_reg  <= WIDTH_REG_W'(1);
            palette_bank_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH_TILES:  width_tiles_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                REG_PALETTE_BANK: palette_bank_reg <= cfg_wdata[BANK_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready     = !s1_valid_reg || !m_valid_reg || m_tready;
    assign word_accept  = s_tvalid && s_tready;
    assign pixel_accept = word_accept && (opcode_t'(s_tuser) == OP_PIXEL);
    assign pal_we       = word_accept && (opcode_t'(s_tuser) == OP_PAL_WRITE);

    t4rgba_locator #(
        .MAX_WIDTH_TILES  (MAX_WIDTH_TILES),
        .MAX_HEIGHT_TILES (MAX_HEIGHT_TILES)
    ) u_locator (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (pixel_accept),
        .last        (s_tlast),
        .width_tiles (width_tiles_reg),
        .pixel_index (pixel_index)
    );

    t4rgba_lane u_lane_even (
        .aclk      (aclk),
        .pal_we    (pal_we),
        .pal_waddr (in_pal_index),
        .pal_wdata (in_pal_color),
        .rd_en     (s_tready),
        .bank      (palette_bank_reg),
        .color_idx (in_source_byte[3:0]),
        .pixel     (even_pixel)
    );

    t4rgba_lane u_lane_odd (
        .aclk      (aclk),
        .pal_we    (pal_we),
        .pal_waddr (in_pal_index),
        .pal_wdata (in_pal_color),
        .rd_en     (s_tready),
        .bank      (palette_bank_reg),
        .color_idx (in_source_byte[7:4]),
        .pixel     (odd_pixel)
    );

    assign s1_valid_next = s_tready ? pixel_accept : s1_valid_reg;
    assign load_out      = s1_valid_reg && (!m_valid_reg || m_tready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            s1_index_reg <= pixel_index;
            s1_last_reg  <= s_tlast;
        end
        if (load_out) begin
            m_data_reg <= {odd_pixel, even_pixel, s1_index_reg};
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/t4rgba_lane.sv =====
// One pixel lane: private palette copy, registered lookup and BGR555 to RGBA8 expansion.
module t4rgba_lane
    import t4rgba_pkg::*;
(
    input  logic                aclk,
    input  logic                pal_we,
    input  logic [PAL_AW-1:0]   pal_waddr,
    input  logic [COLOR_W-1:0]  pal_wdata,
    input  logic                rd_en,
    input  logic [BANK_W-1:0]   bank,
    input  logic [NIBBLE_W-1:0] color_idx,
    output rgba_t               pixel
);

    logic [COLOR_W-1:0]  pal_mem [PAL_DEPTH];
    logic [COLOR_W-1:0]  color_reg;
    logic [NIBBLE_W-1:0] idx_reg;

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[pal_waddr] <= pal_wdata;
        end
        if (rd_en) begin
            color_reg <= pal_mem[{bank, color_idx}];
            idx_reg   <= color_idx;
        end
    end

    always_comb begin
        pixel.red   = EXPAND_LUT[color_reg[CHAN_W-1:0]];
        pixel.green = EXPAND_LUT[color_reg[2*CHAN_W-1:CHAN_W]];
        pixel.blue  = EXPAND_LUT[color_reg[3*CHAN_W-1:2*CHAN_W]];
        pixel.alpha = (idx_reg == '0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    end

endmodule

// ===== rtl/t4rgba_locator.sv =====
// Tile position counters and raster index of the even pixel of each byte.
module t4rgba_locator
    import t4rgba_pkg::*;
#(
    parameter int MAX_WIDTH_TILES  = DEF_MAX_WIDTH_TILES,
    parameter int MAX_HEIGHT_TILES = DEF_MAX_HEIGHT_TILES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   last,
    input  logic [WIDTH_REG_W-1:0] width_tiles,
    output logic [PIX_IDX_W-1:0]   pixel_index
);

    localparam int CW   = (MAX_WIDTH_TILES > 1) ? $clog2(MAX_WIDTH_TILES) : 1;
    localparam int RW   = (MAX_HEIGHT_TILES > 1) ? $clog2(MAX_HEIGHT_TILES) : 1;
    localparam int EW   = $clog2(MAX_WIDTH_TILES + 1);
    localparam int CMPW = ((CW + 1) > EW) ? (CW + 1) : EW;
    localparam int SATW = (WIDTH_REG_W + 1 > EW) ? WIDTH_REG_W + 1 : EW;

    logic [4:0]    byte_reg, byte_next;
    logic [CW-1:0] col_reg,  col_next;
    logic [RW-1:0] row_reg,  row_next;

    logic [EW-1:0]   w_eff;
    logic [CMPW-1:0] col_inc;
    logic [RW:0]     row_inc;
    logic [RW+2:0]   y_pos;
    logic [CW+2:0]   x_pos;
    logic [EW+2:0]   row_pitch;

    always_comb begin
        if (width_tiles == '0) begin
            w_eff = EW'(1);
        end else if (SATW'(width_tiles) > SATW'(MAX_WIDTH_TILES)) begin
            w_eff = EW'(MAX_WIDTH_TILES);
        end else begin
            w_eff = EW'(width_tiles);
        end
    end

    assign y_pos     = {row_reg, byte_reg[4:2]};
    assign x_pos     = {col_reg, byte_reg[1:0], 1'b0};
    assign row_pitch = {w_eff, 3'b000};
    assign pixel_index = PIX_IDX_W'(PIX_IDX_W'(y_pos) * PIX_IDX_W'(row_pitch)
                                    + PIX_IDX_W'(x_pos));

    assign col_inc = CMPW'(col_reg) + CMPW'(1);
    assign row_inc = (RW + 1)'(row_reg) + (RW + 1)'(1);

    always_comb begin
        byte_next = byte_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (advance) begin
            if (last) begin
                byte_next = '0;
                col_next  = '0;
                row_next  = '0;
            end else begin
                byte_next = byte_reg + 5'd1;
                if (byte_reg == 5'd31) begin
                    if (col_inc >= CMPW'(w_eff)) begin
                        col_next = '0;
                        if (row_inc >= (RW + 1)'(MAX_HEIGHT_TILES)) begin
                            row_next = '0;
                        end else begin
                            row_next = row_inc[RW-1:0];
                        end
                    end else begin
                        col_next = col_inc[CW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            byte_reg <= byte_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule
